/* rtl/four_wheel_speed_p_controller_core_assert.svh */
`ifndef FOUR_WHEEL_SPEED_P_CONTROLLER_CORE_ASSERT_SVH
`define FOUR_WHEEL_SPEED_P_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define FWSPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define FWSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fwspc_pkg.sv */
package fwspc_pkg;

    typedef logic [7:0]  duty_t;
    typedef logic [15:0] speed_t;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] REG_FRONT_GAIN   = 2'd1;
    localparam logic [1:0] REG_BACK_GAIN    = 2'd2;
    localparam logic [1:0] REG_PERIOD_TICKS = 2'd3;

    localparam int NUM_WHEELS = 4;

    // wheel order, also the bit order of the input word
    localparam int WHEEL_FR = 0;
    localparam int WHEEL_FL = 1;
    localparam int WHEEL_BR = 2;
    localparam int WHEEL_BL = 3;
    localparam int TICK_BIT = 4;

    // register reset values
    localparam logic [15:0] TARGET_SPEED_RST = 16'd24;
    localparam logic [15:0] FRONT_GAIN_RST   = 16'd8960;
    localparam logic [15:0] BACK_GAIN_RST    = 16'd10752;
    localparam logic [7:0]  PERIOD_TICKS_RST = 8'd10;

    // feed-forward k*target*256 as a shift: k=2 -> 9, k=4 -> 10
    localparam int FF_SHIFT_NORMAL    = 9;
    localparam int FF_SHIFT_BACK_LEFT = 10;

    // 255.0, 1.0 and 256.0 in Q.12
    localparam int DUTY_BIAS_Q12 = 255 * 4096;
    localparam int ONE_Q12       = 4096;
    localparam int FULL_Q12      = 256 * 4096;

    localparam duty_t  DUTY_MAX  = 8'd255;
    localparam speed_t SPEED_MAX = 16'hFFFF;

endpackage

/* rtl/four_wheel_speed_p_controller_core.sv */
// Four-wheel proportional speed controller with feed-forward. Each input word carries
// one encoder edge bit per wheel (front right, front left, back right, back left) and a
// millisecond tick; one word is taken each unstalled cycle. Pulses are counted per wheel,
// saturating at 2^COUNT_WIDTH-1. When period_ticks ticks have been seen (0 acts as 1),
// one result word comes out with the four pulse counts of that period (saturated to
// 16 bits) and four PWM duties, duty = clamp(trunc(255 - (k*target + (target-m)*gain)),
// 0, 255), k = 2 (4 for back left), front_gain for the front pair and back_gain for the
// back pair; the counts then restart. Rate is one word per cycle with no bubbles unless
// stalled. Three register stages (input, period snapshot, output) each hold one word, so
// an upstream stall only happens while a result waits on m_tready and the snapshot is
// also full. Configuration writes take effect on the next edge and are meant for idle
// periods.
module four_wheel_speed_p_controller_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream: [0] pulse_front_right, [1] pulse_front_left, [2] pulse_back_right,
    // [3] pulse_back_left, [4] ms_tick, [7:5] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // result stream: [7:0] duty_front_right, [15:8] duty_front_left,
    // [23:16] duty_back_right, [31:24] duty_back_left, [47:32] speed_front_right,
    // [63:48] speed_front_left, [79:64] speed_back_right, [95:80] speed_back_left
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = COUNT_WIDTH;
    // wide enough for 16*m*gain plus target terms, signed; target*gain alone
    // needs 33 bits, and their sum sets the floor of 34 for narrow counts
    localparam int VW = (COUNT_WIDTH + 24 > 34) ? (COUNT_WIDTH + 24) : 34;
    // width used to saturate counts to 16 bits
    localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    // configuration registers
    logic signed [15:0] target_speed_reg;
    logic [15:0]        front_gain_reg;
    logic [15:0]        back_gain_reg;
    logic [7:0]         period_ticks_reg;

    // stage 1: registered input word
    logic               in_valid_reg;
    logic [4:0]         in_data_reg;

    // period state
    logic [CW-1:0]      count_reg [fwspc_pkg::NUM_WHEELS];
    logic [CW-1:0]      count_next [fwspc_pkg::NUM_WHEELS];
    logic [7:0]         elapsed_reg;
    logic [7:0]         elapsed_next;

    // stage 2: counts of the period just closed
    logic               snap_valid_reg;
    logic [CW-1:0]      snap_count_reg [fwspc_pkg::NUM_WHEELS];

    // stage 3: result word
    logic               out_valid_reg;
    fwspc_pkg::duty_t   out_duty_reg [fwspc_pkg::NUM_WHEELS];
    fwspc_pkg::speed_t  out_speed_reg [fwspc_pkg::NUM_WHEELS];

    fwspc_pkg::duty_t   duty_calc [fwspc_pkg::NUM_WHEELS];
    fwspc_pkg::speed_t  speed_calc [fwspc_pkg::NUM_WHEELS];

    logic               in_adv;
    logic               snap_adv;
    logic               tick;
    logic [7:0]         limit;
    logic               period_end;

    // elastic pipeline: a stage moves when the one after it is empty or moving
    assign snap_adv = !out_valid_reg || m_tready;
    assign in_adv   = !snap_valid_reg || snap_adv;
    assign s_tready = !in_valid_reg || in_adv;

    assign tick       = in_data_reg[fwspc_pkg::TICK_BIT];
    assign limit      = (period_ticks_reg == 8'd0) ? 8'd1 : period_ticks_reg;
    assign period_end = tick && (({1'b0, elapsed_reg} + 9'd1) >= {1'b0, limit});

    // pulse of this word counts before a tick closes the period
    always_comb
    begin
        for (int w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
        begin
            if (in_data_reg[w] && (count_reg[w] != COUNT_MAX))
                count_next[w] = count_reg[w] + CW'(1);
            else
                count_next[w] = count_reg[w];
        end
        elapsed_next = tick ? (elapsed_reg + 8'd1) : elapsed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= signed'(fwspc_pkg::TARGET_SPEED_RST);
            front_gain_reg   <= fwspc_pkg::FRONT_GAIN_RST;
            back_gain_reg    <= fwspc_pkg::BACK_GAIN_RST;
            period_ticks_reg <= fwspc_pkg::PERIOD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fwspc_pkg::REG_TARGET_SPEED: target_speed_reg <= signed'(cfg_data);
                fwspc_pkg::REG_FRONT_GAIN:   front_gain_reg   <= cfg_data;
                fwspc_pkg::REG_BACK_GAIN:    back_gain_reg    <= cfg_data;
                fwspc_pkg::REG_PERIOD_TICKS: period_ticks_reg <= cfg_data[7:0];
                default:                     period_ticks_reg <= period_ticks_reg;
            endcase
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata[4:0];
    end

    // period counters and snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
                count_reg[w] <= '0;
            elapsed_reg    <= 8'd0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_adv)
                snap_valid_reg <= 1'b0;
            if (in_valid_reg && in_adv)
            begin
                if (period_end)
                begin
                    for (int w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
                        count_reg[w] <= '0;
                    elapsed_reg    <= 8'd0;
                    snap_valid_reg <= 1'b1;
                end
                else
                begin
                    for (int w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
                        count_reg[w] <= count_next[w];
                    elapsed_reg <= elapsed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && in_adv && period_end)
        begin
            for (int w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
                snap_count_reg[w] <= count_next[w];
        end
    end

    // stage 2 datapath: one multiplier pair per wheel
    //   v = 255*4096 - k*T*256 - T*G + 16*m*G   (all Q.12)
    for (genvar w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
    begin : g_wheel
        localparam int FF_SHIFT = (w == fwspc_pkg::WHEEL_BL) ?
                                  fwspc_pkg::FF_SHIFT_BACK_LEFT : fwspc_pkg::FF_SHIFT_NORMAL;

        logic [15:0]          gain;
        logic [CW+15:0]       mg;
        logic signed [32:0]   tg;
        logic signed [VW-1:0] ff;
        logic signed [VW-1:0] v;
        logic [EW-1:0]        m_ext;

        assign gain = (w < fwspc_pkg::WHEEL_BR) ? front_gain_reg : back_gain_reg;
        assign mg   = (CW+16)'(snap_count_reg[w]) * (CW+16)'(gain);
        assign tg   = 33'(target_speed_reg) * $signed({1'b0, gain});
        assign ff   = VW'(target_speed_reg) <<< FF_SHIFT;
        assign v    = VW'(fwspc_pkg::DUTY_BIAS_Q12) - (VW'(tg) + ff)
                    + VW'($signed({1'b0, mg, 4'b0000}));

        always_comb
        begin
            if (v < VW'(fwspc_pkg::ONE_Q12))
                duty_calc[w] = '0;
            else if (v >= VW'(fwspc_pkg::FULL_Q12))
                duty_calc[w] = fwspc_pkg::DUTY_MAX;
            else
                duty_calc[w] = v[19:12];
        end

        assign m_ext         = EW'(snap_count_reg[w]);
        assign speed_calc[w] = (m_ext > EW'(fwspc_pkg::SPEED_MAX)) ?
                               fwspc_pkg::SPEED_MAX : m_ext[15:0];
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_adv)
            out_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv && snap_valid_reg)
        begin
            for (int w = 0; w < fwspc_pkg::NUM_WHEELS; w++)
            begin
                out_duty_reg[w]  <= duty_calc[w];
                out_speed_reg[w] <= speed_calc[w];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_speed_reg[fwspc_pkg::WHEEL_BL], out_speed_reg[fwspc_pkg::WHEEL_BR],
                       out_speed_reg[fwspc_pkg::WHEEL_FL], out_speed_reg[fwspc_pkg::WHEEL_FR],
                       out_duty_reg[fwspc_pkg::WHEEL_BL],  out_duty_reg[fwspc_pkg::WHEEL_BR],
                       out_duty_reg[fwspc_pkg::WHEEL_FL],  out_duty_reg[fwspc_pkg::WHEEL_FR]};

endmodule

/* rtl/fwspc_checker.sv */
`include "four_wheel_speed_p_controller_core_assert.svh"

module fwspc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a stalled result word holds
    `FWSPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed under stall")

    // with the output empty, nothing upstream can be blocked
    `FWSPC_ASSERT_NOW(a_ready_when_drained, !m_tvalid, s_tready, "input stalled with empty output")

    // front pair shares gain and feed-forward: equal speeds give equal duties
    `FWSPC_ASSERT_NOW(a_front_pair_match, m_tvalid && (m_tdata[47:32] == m_tdata[63:48]), m_tdata[7:0] == m_tdata[15:8], "front duties differ at equal speed")

endmodule

bind four_wheel_speed_p_controller_core fwspc_checker u_fwspc_checker (.*);

/* tb/four_wheel_speed_p_controller_core_tb.sv */
`timescale 1ns / 1ps

module four_wheel_speed_p_controller_core_tb;

    // run limit in clock cycles; the worst correct run (sparsest sender bursts
    // against the longest receiver stalls) stays far under this
    localparam int CYCLE_LIMIT   = 2_000_000;
    // result passes the snapshot and output registers after the closing word; leave some margin
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 1500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    four_wheel_speed_p_controller_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller shadow: register copies, per-wheel pulse counts, tick count
    // ------------------------------------------------------------------
    logic signed [15:0] target_q   = fwspc_pkg::TARGET_SPEED_RST;
    logic [15:0]        fgain_q    = fwspc_pkg::FRONT_GAIN_RST;
    logic [15:0]        bgain_q    = fwspc_pkg::BACK_GAIN_RST;
    logic [7:0]         period_q   = fwspc_pkg::PERIOD_TICKS_RST;
    logic [15:0]        wheel_pulses [fwspc_pkg::NUM_WHEELS];
    logic [7:0]         tick_count = 8'd0;

    // duty/speed words still to come out, oldest first (m_tdata layout)
    logic [95:0] duty_speed_q [$];
    // encoder/tick words waiting for the driver
    logic [4:0]  edge_tick_q [$];

    int pending_words = 0;   // pushed but not yet accepted
    int results_due   = 0;   // duty/speed words predicted so far
    int random_words  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int gap_left      = 0;
    int burst_left    = 1;
    int ready_mode    = 0;

    initial
    begin
        for (int i = 0; i < fwspc_pkg::NUM_WHEELS; i++)
            wheel_pulses[i] = 16'd0;
    end

    // Q.12 duty: v = 255 - (k*target + (target - m)*gain), trunc, clamp
    function automatic logic [7:0] wheel_duty(input logic [15:0] pulses,
                                              input logic [15:0] gain,
                                              input longint ff_k);
        longint tgt;
        longint err_q4;
        longint ff_q12;
        longint v;
        tgt    = longint'(target_q);
        err_q4 = tgt - longint'(pulses) * 16;
        ff_q12 = ff_k * tgt * 256;
        v      = longint'(255) * 4096 - (ff_q12 + err_q4 * longint'(gain));
        if (v < 4096)
            return 8'd0;
        if (v >= longint'(256) * 4096)
            return 8'd255;
        return 8'(v / 4096);
    endfunction

    // advance the shadow by one accepted word; queue a duty/speed word
    // when the tick closes the period
    task automatic wheel_ctrl_step(input logic [4:0] w);
        int          limit;
        logic [95:0] r;
        logic [15:0] gain;
        longint      ff_k;
        // pulse is counted before the tick, so it lands in the closing period
        for (int i = 0; i < fwspc_pkg::NUM_WHEELS; i++)
            if (w[i] && wheel_pulses[i] != 16'hFFFF)
                wheel_pulses[i] = wheel_pulses[i] + 16'd1;
        if (!w[fwspc_pkg::TICK_BIT])
            return;
        limit = (period_q == 8'd0) ? 1 : int'(period_q);   // zero period acts as one
        if (int'(tick_count) + 1 < limit)
        begin
            tick_count = tick_count + 8'd1;
            return;
        end
        tick_count = 8'd0;
        r = '0;
        for (int i = 0; i < fwspc_pkg::NUM_WHEELS; i++)
        begin
            gain = (i == fwspc_pkg::WHEEL_FR || i == fwspc_pkg::WHEEL_FL) ? fgain_q : bgain_q;
            ff_k = (i == fwspc_pkg::WHEEL_BL) ? 4 : 2;
            r[8*i +: 8]        = wheel_duty(wheel_pulses[i], gain, ff_k);
            r[32 + 16*i +: 16] = wheel_pulses[i];
            wheel_pulses[i]    = 16'd0;
        end
        duty_speed_q.push_back(r);
        results_due++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps, word held while stalled
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drv
        logic hold;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'd0;
            gap_left   = 0;
            burst_left = 1;
        end
        else
        begin
            hold = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
            begin
                wheel_ctrl_step(s_tdata[4:0]);
                pending_words--;
            end
            if (!hold)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (edge_tick_q.size() > 0)
                begin
                    s_tdata  <= {3'b000, edge_tick_q.pop_front()};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // about half the bursts run straight into the next
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: receiver stall pattern plus field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : mon
        logic [95:0] want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (duty_speed_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = duty_speed_q.pop_front();
                    for (int i = 0; i < fwspc_pkg::NUM_WHEELS; i++)
                    begin
                        if (m_tdata[8*i +: 8] !== want[8*i +: 8])
                        begin
                            $display("%0t: duty wheel %0d expected %0d got %0d",
                                     $time, i, want[8*i +: 8], m_tdata[8*i +: 8]);
                            fail_count++;
                        end
                        if (m_tdata[32 + 16*i +: 16] !== want[32 + 16*i +: 16])
                        begin
                            $display("%0t: speed wheel %0d expected %0d got %0d",
                                     $time, i, want[32 + 16*i +: 16],
                                     m_tdata[32 + 16*i +: 16]);
                            fail_count++;
                        end
                    end
                end
            end
            // stall pattern is picked anew at random from the four modes below
            if (cycle_count % 64 == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0: m_tready <= 1'b1;                              // never stalls
                1: m_tready <= ($urandom_range(0, 1) == 1);       // coin flip
                2: m_tready <= ($urandom_range(0, 7) == 0);       // long stalls
                default: m_tready <= cycle_count[1];              // follows bit 1 of the cycle count
            endcase
        end
    end

    // cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic [4:0] w);
        pending_words++;
        edge_tick_q.push_back(w);
    endtask

    // hold off until every word is in and every result is out, then let
    // any tick-only word still in the pipe clear
    task automatic drain();
        while (pending_words != 0 || duty_speed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            fwspc_pkg::REG_TARGET_SPEED: target_q = val;
            fwspc_pkg::REG_FRONT_GAIN:   fgain_q  = val;
            fwspc_pkg::REG_BACK_GAIN:    bgain_q  = val;
            default:                     period_q = val[7:0];
        endcase
    endtask

    // only called with the block idle
    task automatic apply_settings(input logic [15:0] tgt, input logic [15:0] fg,
                                  input logic [15:0] bg, input logic [7:0] per);
        drain();
        write_reg(fwspc_pkg::REG_TARGET_SPEED, tgt);
        write_reg(fwspc_pkg::REG_FRONT_GAIN, fg);
        write_reg(fwspc_pkg::REG_BACK_GAIN, bg);
        write_reg(fwspc_pkg::REG_PERIOD_TICKS, {8'd0, per});
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : seq
        int          n_words;
        int          pulse_pct;
        int          tick_pct;
        logic [15:0] tgt;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  per;
        logic [4:0]  w;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one full 10-tick period, last tick with all pulses
        push_word(5'h0F);
        push_word(5'h00);
        push_word(5'h05);
        push_word(5'h0A);
        push_word(5'h11);
        push_word(5'h12);
        push_word(5'h14);
        push_word(5'h18);
        repeat (5) push_word(5'h10);
        push_word(5'h1F);

        // zero period, top target, full front gain, no back gain
        apply_settings(16'h7FFF, 16'hFFFF, 16'h0000, 8'd0);
        push_word(5'h10);
        push_word(5'h1F);

        // most negative target, gains swapped to the other extremes
        apply_settings(16'h8000, 16'h0000, 16'hFFFF, 8'd1);
        push_word(5'h10);
        push_word(5'h1F);
        push_word(5'h15);

        // target 1.0, gain 1.0, two-tick period: unclamped duties
        apply_settings(16'h0010, 16'h0100, 16'h0100, 8'd2);
        push_word(5'h01);
        push_word(5'h12);
        push_word(5'h1C);

        // random phases, each with its own settings
        while (random_words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: tgt = 16'h7FFF;
                    1: tgt = 16'h8000;
                    2: tgt = 16'h0000;
                    default: tgt = 16'hFFFF;
                endcase
                fg = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                bg = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            end
            else
            begin
                tgt = 16'($urandom_range(0, 800));
                if ($urandom_range(0, 5) == 0)
                    tgt = -tgt;
                fg = 16'($urandom_range(0, 2048));
                bg = 16'($urandom_range(0, 2048));
                if ($urandom_range(0, 7) == 0)
                    tgt = 16'($urandom_range(0, 65535));
            end
            n_words   = $urandom_range(60, 160);
            pulse_pct = $urandom_range(0, 100);
            tick_pct  = $urandom_range(20, 100);
            case ($urandom_range(0, 9))
                0: per = 8'd0;
                1:
                begin
                    // longest period: tick every word to close it at all
                    per      = 8'd255;
                    n_words  = 300;
                    tick_pct = 100;
                end
                default: per = 8'($urandom_range(1, 6));
            endcase
            apply_settings(tgt, fg, bg, per);
            for (int k = 0; k < n_words; k++)
            begin
                for (int b = 0; b < fwspc_pkg::NUM_WHEELS; b++)
                    w[b] = ($urandom_range(0, 99) < pulse_pct);
                w[fwspc_pkg::TICK_BIT] = ($urandom_range(0, 99) < tick_pct);
                push_word(w);
                random_words++;
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
